/* sv/filament_slot_command_decoder_defines.svh */
// Assertion macros shared by the decoder RTL.
// Depends on nothing; users provide aclk and aresetn in scope.
`ifndef FILAMENT_SLOT_COMMAND_DECODER_DEFINES_SVH
`define FILAMENT_SLOT_COMMAND_DECODER_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define FSCD_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("fscd: invariant violated");

// Consequent must hold in the cycle after the antecedent.
`define FSCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fscd: sequence violated");

`endif

/* sv/fscd_pkg.sv */
// Package for the filament slot command decoder: field widths, command
// colors, decoded command codes and the queue entry type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fscd_pkg;

    localparam int SLOTS         = 4;
    localparam int CHANNEL_CODES = 16;
    localparam int SLOT_W        = $clog2(SLOTS);
    localparam int TARGET_W      = 4;
    localparam int UNIT_W        = 2;
    localparam int CHAN_W        = 2;
    localparam int OP_W          = 2;
    localparam int NAME_W        = 64;
    localparam int COLOR_W       = 32;

    localparam int S_DATA_W = 104;
    localparam int M_DATA_W = 32;

    // Decode queue depth and its pointer and count widths
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Operation codes on s_tuser
    localparam logic [OP_W-1:0] OP_MSG    = 2'd0;
    localparam logic [OP_W-1:0] OP_SELECT = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // Command name "TPU-AMS" plus a zero byte, and command colors
    localparam logic [NAME_W-1:0]  CMD_NAME   = 64'h5450_552D_414D_5300;
    localparam logic [COLOR_W-1:0] COL_SLOT0  = 32'hAF79_33FF;
    localparam logic [COLOR_W-1:0] COL_SLOT1  = 32'h8989_89FF;
    localparam logic [COLOR_W-1:0] COL_SLOT2  = 32'hBCBC_BCFF;
    localparam logic [COLOR_W-1:0] COL_SLOT3  = 32'h1616_16FF;
    localparam logic [15:0]        COL_DIRECT_HI = 16'h4061;
    localparam logic [COLOR_W-1:0] COL_AUTO   = 32'hD3C5_A3FF;
    localparam logic [COLOR_W-1:0] COL_CLAIM  = 32'hFFFF_FFFF;
    localparam logic [COLOR_W-1:0] COL_RESET  = 32'hFFF1_44FF;

    // Decoded command kinds
    typedef enum logic [3:0] {
        CMD_PASS,
        CMD_SLOT,
        CMD_DIRECT,
        CMD_AUTO,
        CMD_CLAIM,
        CMD_RESET,
        CMD_SWITCH,
        CMD_SELECT,
        CMD_CLEAR,
        CMD_NOP
    } cmd_t;

    // One decoded item as it waits in the queue
    typedef struct packed {
        cmd_t                cmd;
        logic [SLOT_W-1:0]   slot;
        logic [CHAN_W-1:0]   channel;
        logic [UNIT_W-1:0]   unit;
        logic [TARGET_W-1:0] code;
        logic                code_ok;
        logic                clr_save;
        logic                clr_delay;
        logic                clr_pullcheck;
    } entry_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic valid;
        logic full;
    } qstat_t;

endpackage

`default_nettype wire

/* sv/fscd_front.sv */
// Front end: takes input items and decodes them into queue entries.
// Depends on fscd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fscd_front import fscd_pkg::*; (
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // tdata: name_bytes[63:0], color[95:64], channel[97:96], unit[99:98],
    //        clear_save[100], clear_delay[101], clear_pullcheck[102], pad[103]
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // tuser: operation[1:0]
    input  wire logic [OP_W-1:0]     s_tuser,
    input  wire qstat_t              q_stat,
    output logic                     push,
    output entry_t                   entry
);

    logic [NAME_W-1:0]  name_bytes;
    logic [COLOR_W-1:0] color;

    assign name_bytes = s_tdata[63:0];
    assign color      = s_tdata[95:64];

    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && !q_stat.full;

    // Classify the item
    always_comb begin
        entry               = '0;
        entry.cmd           = CMD_NOP;
        entry.channel       = s_tdata[97:96];
        entry.unit          = s_tdata[99:98];
        entry.clr_save      = s_tdata[100];
        entry.clr_delay     = s_tdata[101];
        entry.clr_pullcheck = s_tdata[102];
        entry.code          = color[8 +: TARGET_W];
        entry.code_ok       = color[15:8] < 8'(CHANNEL_CODES);
        unique case (s_tuser)
            OP_MSG: begin
                if (name_bytes != CMD_NAME) begin
                    entry.cmd = CMD_PASS;
                end else if (color == COL_SLOT0) begin
                    entry.cmd  = CMD_SLOT;
                    entry.slot = SLOT_W'(0);
                end else if (color == COL_SLOT1) begin
                    entry.cmd  = CMD_SLOT;
                    entry.slot = SLOT_W'(1);
                end else if (color == COL_SLOT2) begin
                    entry.cmd  = CMD_SLOT;
                    entry.slot = SLOT_W'(2);
                end else if (color == COL_SLOT3) begin
                    entry.cmd  = CMD_SLOT;
                    entry.slot = SLOT_W'(3);
                end else if (color[31:16] == COL_DIRECT_HI) begin
                    entry.cmd = CMD_DIRECT;
                end else if (color == COL_AUTO) begin
                    entry.cmd = CMD_AUTO;
                end else if (color == COL_CLAIM) begin
                    // unit comparison happens in the back end
                    entry.cmd = CMD_CLAIM;
                end else if (color == COL_RESET) begin
                    entry.cmd = CMD_RESET;
                end else begin
                    entry.cmd = CMD_SWITCH;
                end
            end
            OP_SELECT: entry.cmd = CMD_SELECT;
            OP_CLEAR:  entry.cmd = CMD_CLEAR;
            default:   entry.cmd = CMD_NOP;
        endcase
    end

endmodule

`default_nettype wire

/* sv/fscd_queue.sv */
// Two-entry queue of decoded items between front and back end.
// Depends on fscd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fscd_queue import fscd_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push,
    input  wire entry_t push_entry,
    input  wire logic   pop,
    output entry_t      head,
    output qstat_t      q_stat
);

    entry_t              entries_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign q_stat.valid = (count_reg != '0);
    assign q_stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign head         = entries_reg[rd_ptr_reg];

    assign do_push = push && !q_stat.full;
    assign do_pop  = pop && q_stat.valid;

    // Pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

/* sv/fscd_back.sv */
// Back end: applies decoded commands to the slot map, unit numbers and
// flags, and holds the result in an output register. Depends on fscd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fscd_back import fscd_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire qstat_t              q_stat,
    input  wire entry_t              head,
    output logic                     pop,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // tdata: accepted[0], slot0_target[4:1], slot1_target[8:5],
    //        slot2_target[12:9], slot3_target[16:13], own_unit[18:17],
    //        current_unit[20:19], save_pending[21], delay_pending[22],
    //        auto_ready[23], long_pull[24], pull_check_flag[25], pad[31:26]
    output logic [M_DATA_W-1:0]      m_tdata
);

    logic [TARGET_W-1:0] slot_map_reg [SLOTS];
    logic [TARGET_W-1:0] slot_map_next [SLOTS];
    logic [UNIT_W-1:0]   own_unit_reg, own_unit_next;
    logic [UNIT_W-1:0]   cur_unit_reg, cur_unit_next;
    logic                save_reg, save_next;
    logic                delay_reg, delay_next;
    logic                auto_reg, auto_next;
    logic                longpull_reg, longpull_next;
    logic                pullcheck_reg, pullcheck_next;
    logic                accepted;
    logic                units_equal;
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    assign pop         = q_stat.valid && (!m_tvalid_reg || m_tready);
    assign units_equal = (own_unit_reg == cur_unit_reg);

    // Command execution
    always_comb begin
        for (int k = 0; k < SLOTS; k++) begin
            slot_map_next[k] = slot_map_reg[k];
        end
        own_unit_next  = own_unit_reg;
        cur_unit_next  = cur_unit_reg;
        save_next      = save_reg;
        delay_next     = delay_reg;
        auto_next      = auto_reg;
        longpull_next  = longpull_reg;
        pullcheck_next = pullcheck_reg;
        accepted       = 1'b0;
        unique case (head.cmd) inside
            CMD_PASS: accepted = units_equal;
            CMD_SLOT: begin
                slot_map_next[head.slot] = {cur_unit_reg, head.channel};
                save_next = 1'b1;
            end
            CMD_DIRECT: begin
                if (head.code_ok) begin
                    slot_map_next[SLOT_W'(head.channel)] = head.code;
                end
                longpull_next  = 1'b1;
                pullcheck_next = 1'b1;
                save_next      = 1'b1;
            end
            CMD_AUTO: begin
                auto_next = 1'b1;
                save_next = 1'b1;
            end
            CMD_CLAIM: begin
                // only this unit may take a new number
                if (units_equal) begin
                    own_unit_next = head.channel;
                    longpull_next = 1'b0;
                end
                save_next = 1'b1;
            end
            CMD_RESET, CMD_SWITCH: begin
                if (head.cmd == CMD_RESET) begin
                    for (int k = 0; k < SLOTS; k++) begin
                        slot_map_next[k] = {head.channel, SLOT_W'(k)};
                    end
                end
                cur_unit_next  = head.channel;
                delay_next     = 1'b1;
                auto_next      = 1'b0;
                longpull_next  = 1'b1;
                pullcheck_next = 1'b1;
                save_next      = 1'b1;
            end
            CMD_SELECT: cur_unit_next = head.unit;
            CMD_CLEAR: begin
                if (head.clr_save)      save_next      = 1'b0;
                if (head.clr_delay)     delay_next     = 1'b0;
                if (head.clr_pullcheck) pullcheck_next = 1'b0;
            end
            default: ;
        endcase
    end

    // Result word from the updated state
    always_comb begin
        m_tdata_next        = '0;
        m_tdata_next[0]     = accepted;
        for (int k = 0; k < SLOTS; k++) begin
            m_tdata_next[1 + k*TARGET_W +: TARGET_W] = slot_map_next[k];
        end
        m_tdata_next[18:17] = own_unit_next;
        m_tdata_next[20:19] = cur_unit_next;
        m_tdata_next[21]    = save_next;
        m_tdata_next[22]    = delay_next;
        m_tdata_next[23]    = auto_next;
        m_tdata_next[24]    = longpull_next;
        m_tdata_next[25]    = pullcheck_next;
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < SLOTS; k++) begin
                slot_map_reg[k] <= TARGET_W'(k);
            end
            own_unit_reg  <= '0;
            cur_unit_reg  <= '0;
            save_reg      <= 1'b0;
            delay_reg     <= 1'b0;
            auto_reg      <= 1'b0;
            longpull_reg  <= 1'b0;
            pullcheck_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (pop) begin
                for (int k = 0; k < SLOTS; k++) begin
                    slot_map_reg[k] <= slot_map_next[k];
                end
                own_unit_reg  <= own_unit_next;
                cur_unit_reg  <= cur_unit_next;
                save_reg      <= save_next;
                delay_reg     <= delay_next;
                auto_reg      <= auto_next;
                longpull_reg  <= longpull_next;
                pullcheck_reg <= pullcheck_next;
                m_tvalid_reg  <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg  <= 1'b0;
            end
        end
    end

    // Output payload, no reset
    always_ff @(posedge aclk) begin
        if (pop) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

/* sv/filament_slot_command_decoder.sv */
// An accepted item is written into the queue; the back end applies it when it pops
// and holds its result in the output register until m_tready takes it.
// Throughput: one item per cycle while m_tready is high. A held result stalls
// the back end; the two-entry queue fills, then s_tready drops.
// Reset (aresetn low, synchronous): slot map 0,1,2,3, own and current unit
// 0, all flags clear, queue empty, no result pending.
`timescale 1ns / 1ps
`default_nettype none
`include "filament_slot_command_decoder_defines.svh"

module filament_slot_command_decoder import fscd_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // tdata: name_bytes[63:0], color[95:64], channel[97:96], unit[99:98],
    //        clear_save[100], clear_delay[101], clear_pullcheck[102], pad[103]
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // tuser: operation[1:0]
    input  wire logic [OP_W-1:0]     s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // tdata: accepted[0], slot0_target[4:1], slot1_target[8:5],
    //        slot2_target[12:9], slot3_target[16:13], own_unit[18:17],
    //        current_unit[20:19], save_pending[21], delay_pending[22],
    //        auto_ready[23], long_pull[24], pull_check_flag[25], pad[31:26]
    output logic [M_DATA_W-1:0]      m_tdata
);

    qstat_t q_stat;
    entry_t push_entry;
    entry_t head;
    logic   push;
    logic   pop;

    fscd_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_stat   (q_stat),
        .push     (push),
        .entry    (push_entry)
    );

    fscd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    fscd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // An accepted message only ever reports matching unit numbers
    `FSCD_ASSERT_ALWAYS(a_acc_units, !(m_tvalid && m_tdata[0]) || m_tdata[18:17] == m_tdata[20:19])
    // Front stalls only on a full queue, and a full queue is never empty
    `FSCD_ASSERT_ALWAYS(a_stall_full, s_tready || (q_stat.full && q_stat.valid))
    // A popped item always produces a result next cycle
    `FSCD_ASSERT_NEXT(a_pop_result, pop, m_tvalid)

endmodule

`default_nettype wire

/* tb/filament_slot_command_decoder_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for filament_slot_command_decoder: a directed table, then
// random filament messages, unit selects and flag clears checked by a status
// predictor. Depends on fscd_pkg and the decoder RTL.

module filament_slot_command_decoder_test;
    import fscd_pkg::*;

    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int HOLD_OFF_CYCLES = 40;
    localparam int DRAIN_CYCLES = 10;

    // One input item, as it goes onto s_tdata / s_tuser
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [NAME_W-1:0]  name;
        logic [COLOR_W-1:0] color;
        logic [CHAN_W-1:0]  channel;
        logic [UNIT_W-1:0]  unit;
        logic               clr_save;
        logic               clr_delay;
        logic               clr_pullcheck;
    } msg_item_t;

    // Status word, laid out as on m_tdata from the top bit down
    typedef struct packed {
        logic [5:0]          pad;
        logic                pull_check_flag;
        logic                long_pull;
        logic                auto_ready;
        logic                delay_pending;
        logic                save_pending;
        logic [UNIT_W-1:0]   current_unit;
        logic [UNIT_W-1:0]   own_unit;
        logic [TARGET_W-1:0] slot3_target;
        logic [TARGET_W-1:0] slot2_target;
        logic [TARGET_W-1:0] slot1_target;
        logic [TARGET_W-1:0] slot0_target;
        logic                accepted;
    } status_t;

    typedef struct {
        msg_item_t item;
        bit        known;
        status_t   status;
    } table_row_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [OP_W-1:0]     s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    // Predicted decoder state
    logic [TARGET_W-1:0] pred_map [SLOTS];
    logic [UNIT_W-1:0]   pred_own;
    logic [UNIT_W-1:0]   pred_cur;
    logic                pred_save;
    logic                pred_delay;
    logic                pred_auto;
    logic                pred_longpull;
    logic                pred_pullcheck;

    status_t expected_status_q [$];
    int      mismatch_count = 0;
    int      send_idle_pct  = 33;
    int      recv_idle_pct  = 66;
    int      stall_request  = 0;

    filament_slot_command_decoder u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Apply one item to the predicted state and return the status it yields
    function automatic status_t decode_filament_item(msg_item_t it);
        status_t             st;
        logic [TARGET_W-1:0] target;
        logic                acc;
        int                  k;
        acc    = 1'b0;
        target = {pred_cur, it.channel};
        if (it.op == OP_MSG) begin
            if (it.name != CMD_NAME) begin
                acc = (pred_own == pred_cur);
            end else begin
                if (it.color == COL_SLOT0) begin
                    pred_map[0] = target;
                end else if (it.color == COL_SLOT1) begin
                    pred_map[1] = target;
                end else if (it.color == COL_SLOT2) begin
                    pred_map[2] = target;
                end else if (it.color == COL_SLOT3) begin
                    pred_map[3] = target;
                end else if (it.color[31:16] == COL_DIRECT_HI) begin
                    // out-of-range channel code leaves the slot alone
                    if (it.color[15:8] < CHANNEL_CODES)
                        pred_map[it.channel] = it.color[11:8];
                    pred_longpull  = 1'b1;
                    pred_pullcheck = 1'b1;
                end else if (it.color == COL_AUTO) begin
                    pred_auto = 1'b1;
                end else if (pred_own == pred_cur && it.color == COL_CLAIM) begin
                    pred_own      = it.channel;
                    pred_longpull = 1'b0;
                end else if (it.color != COL_CLAIM) begin
                    // unit reset rebuilds the map, any other color just switches
                    if (it.color == COL_RESET) begin
                        for (k = 0; k < SLOTS; k++)
                            pred_map[k] = {it.channel, 2'(k)};
                    end
                    pred_cur       = it.channel;
                    pred_delay     = 1'b1;
                    pred_auto      = 1'b0;
                    pred_longpull  = 1'b1;
                    pred_pullcheck = 1'b1;
                end
                pred_save = 1'b1;
            end
        end else if (it.op == OP_SELECT) begin
            pred_cur = it.unit;
        end else if (it.op == OP_CLEAR) begin
            if (it.clr_save)      pred_save      = 1'b0;
            if (it.clr_delay)     pred_delay     = 1'b0;
            if (it.clr_pullcheck) pred_pullcheck = 1'b0;
        end
        st                 = '0;
        st.accepted        = acc;
        st.slot0_target    = pred_map[0];
        st.slot1_target    = pred_map[1];
        st.slot2_target    = pred_map[2];
        st.slot3_target    = pred_map[3];
        st.own_unit        = pred_own;
        st.current_unit    = pred_cur;
        st.save_pending    = pred_save;
        st.delay_pending   = pred_delay;
        st.auto_ready      = pred_auto;
        st.long_pull       = pred_longpull;
        st.pull_check_flag = pred_pullcheck;
        return st;
    endfunction

    function automatic msg_item_t mk_item(logic [OP_W-1:0] op, logic [NAME_W-1:0] name,
                                          logic [COLOR_W-1:0] color, logic [CHAN_W-1:0] ch,
                                          logic [UNIT_W-1:0] unit, logic [2:0] clr);
        msg_item_t it;
        it.op            = op;
        it.name          = name;
        it.color         = color;
        it.channel       = ch;
        it.unit          = unit;
        it.clr_save      = clr[0];
        it.clr_delay     = clr[1];
        it.clr_pullcheck = clr[2];
        return it;
    endfunction

    // slots = {s3,s2,s1,s0}, flags = {pullcheck,longpull,auto,delay,save}
    function automatic status_t known_status(logic acc, logic [15:0] slots,
                                             logic [UNIT_W-1:0] own, logic [UNIT_W-1:0] cur,
                                             logic [4:0] flags);
        return {6'b0, flags, cur, own, slots, acc};
    endfunction

    // Mostly well-formed command messages, some plain messages, selects, clears and reserved operations
    function automatic msg_item_t random_item();
        msg_item_t it;
        int        pick;
        it = mk_item(OP_MSG, {$urandom, $urandom}, $urandom, 2'($urandom),
                     2'($urandom), 3'($urandom));
        pick = $urandom_range(99);
        if (pick < 9)
            it.op = OP_SELECT;
        else if (pick < 18)
            it.op = OP_CLEAR;
        else if (pick < 22)
            it.op = OP_RESERVED;
        if ($urandom_range(99) < 75) begin
            it.name = CMD_NAME;
            case ($urandom_range(9))
                0: it.color = COL_SLOT0;
                1: it.color = COL_SLOT1;
                2: it.color = COL_SLOT2;
                3: it.color = COL_SLOT3;
                4: it.color = {COL_DIRECT_HI,
                               ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(15)),
                               8'($urandom)};
                5: it.color = COL_AUTO;
                6: it.color = COL_CLAIM;
                7: it.color = COL_RESET;
                default: ;
            endcase
        end else if ($urandom_range(2) == 0) begin
            // near miss on the command name
            it.name = CMD_NAME ^ (64'd1 << $urandom_range(63));
        end
        return it;
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endfunction

    // Offer one item, starting at a falling edge; returns at a falling edge
    task automatic send_item(msg_item_t it, bit known, status_t st);
        status_t pred;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= {1'b0, it.clr_pullcheck, it.clr_delay, it.clr_save,
                     it.unit, it.channel, it.color, it.name};
        do @(posedge aclk); while (!s_tready);
        pred = decode_filament_item(it);
        expected_status_q.push_back(known ? st : pred);
        @(negedge aclk);
    endtask

    // Stimulus
    initial begin
        table_row_t rows [$];
        int         phase;
        int         k;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        for (k = 0; k < SLOTS; k++)
            pred_map[k] = 4'(k);
        pred_own       = '0;
        pred_cur       = '0;
        pred_save      = 1'b0;
        pred_delay     = 1'b0;
        pred_auto      = 1'b0;
        pred_longpull  = 1'b0;
        pred_pullcheck = 1'b0;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table: reset state, ignored codes, every command, selects, clears
        rows.push_back('{mk_item(OP_MSG, '0, '0, 2'd0, 2'd0, 3'b000), 1'b1,
                         known_status(1'b1, 16'h3210, 2'd0, 2'd0, 5'b00000)});
        rows.push_back('{mk_item(OP_RESERVED, '1, '1, 2'd3, 2'd3, 3'b111), 1'b1,
                         known_status(1'b0, 16'h3210, 2'd0, 2'd0, 5'b00000)});
        rows.push_back('{mk_item(OP_CLEAR, '0, '0, 2'd0, 2'd0, 3'b111), 1'b1,
                         known_status(1'b0, 16'h3210, 2'd0, 2'd0, 5'b00000)});
        rows.push_back('{mk_item(OP_MSG, CMD_NAME, COL_SLOT0, 2'd3, 2'd0, 3'b000), 1'b1,
                         known_status(1'b0, 16'h3213, 2'd0, 2'd0, 5'b00001)});
        rows.push_back('{mk_item(OP_MSG, CMD_NAME, COL_SLOT1, 2'd2, 2'd0, 3'b000), 1'b0, '0});
        rows.push_back('{mk_item(OP_MSG, CMD_NAME, COL_SLOT2, 2'd1, 2'd0, 3'b000), 1'b0, '0});
        rows.push_back('{mk_item(OP_MSG, CMD_NAME, COL_SLOT3, 2'd0, 2'd0, 3'b000), 1'b0, '0});
        rows.push_back('{mk_item(OP_MSG, CMD_NAME, 32'h4061_0F00, 2'd3, 2'd0, 3'b000), 1'b0, '0});
        rows.push_back('{mk_item(OP_MSG, CMD_NAME, 32'h4061_10FF, 2'd0, 2'd0, 3'b000), 1'b0, '0});
        rows.push_back('{mk_item(OP_MSG, CMD_NAME, 32'h4061_FFAA, 2'd1, 2'd0, 3'b000), 1'b0, '0});
        rows.push_back('{mk_item(OP_MSG, CMD_NAME, 32'h4061_0011, 2'd2, 2'd0, 3'b000), 1'b0, '0});
        rows.push_back('{mk_item(OP_MSG, CMD_NAME, COL_AUTO, 2'd0, 2'd0, 3'b000), 1'b0, '0});
        rows.push_back('{mk_item(OP_MSG, CMD_NAME, COL_CLAIM, 2'd2, 2'd0, 3'b000), 1'b0, '0});
        rows.push_back('{mk_item(OP_MSG, '1, 32'h1234_5678, 2'd1, 2'd0, 3'b000), 1'b0, '0});
        rows.push_back('{mk_item(OP_MSG, CMD_NAME, COL_CLAIM, 2'd1, 2'd0, 3'b000), 1'b0, '0});
        rows.push_back('{mk_item(OP_MSG, CMD_NAME, COL_RESET, 2'd2, 2'd0, 3'b000), 1'b0, '0});
        rows.push_back('{mk_item(OP_MSG, CMD_NAME ^ 64'd1, COL_SLOT0, 2'd0, 2'd0, 3'b000),
                         1'b0, '0});
        rows.push_back('{mk_item(OP_MSG, CMD_NAME, '0, 2'd1, 2'd0, 3'b000), 1'b0, '0});
        rows.push_back('{mk_item(OP_MSG, CMD_NAME, 32'hFFFF_FFFE, 2'd3, 2'd0, 3'b000),
                         1'b0, '0});
        rows.push_back('{mk_item(OP_SELECT, '0, '0, 2'd0, 2'd0, 3'b000), 1'b0, '0});
        rows.push_back('{mk_item(OP_SELECT, '0, '0, 2'd0, 2'd3, 3'b000), 1'b0, '0});
        rows.push_back('{mk_item(OP_MSG, CMD_NAME, COL_SLOT3, 2'd3, 2'd0, 3'b000), 1'b0, '0});
        rows.push_back('{mk_item(OP_CLEAR, '0, '0, 2'd0, 2'd0, 3'b001), 1'b0, '0});
        rows.push_back('{mk_item(OP_CLEAR, '0, '0, 2'd0, 2'd0, 3'b010), 1'b0, '0});
        rows.push_back('{mk_item(OP_CLEAR, '0, '0, 2'd0, 2'd0, 3'b100), 1'b0, '0});
        rows.push_back('{mk_item(OP_MSG, '0, '0, 2'd3, 2'd2, 3'b111), 1'b0, '0});
        foreach (rows[i])
            send_item(rows[i].item, rows[i].known, rows[i].status);

        // Random phases with different idle mixes
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 33; recv_idle_pct = 66; end
                1: begin send_idle_pct = 66; recv_idle_pct = 33; end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    stall_request = HOLD_OFF_CYCLES;
                end
            endcase
            repeat (ITEMS_PER_PHASE)
                send_item(random_item(), 1'b0, '0);
            // let every pending status drain before the next phase
            s_tvalid <= 1'b0;
            while (expected_status_q.size() != 0)
                @(negedge aclk);
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("filament_slot_command_decoder verification clean");
        else
            $display("filament_slot_command_decoder verification failed");
        $finish;
    end

    // Receiver: random backpressure plus a long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_request > 0) begin
                hold_left     = stall_request;
                stall_request = 0;
            end
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Status checker
    always @(posedge aclk) begin
        status_t want;
        status_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = status_t'(m_tdata);
            if (expected_status_q.size() == 0) begin
                $error("status item with none expected: %h", m_tdata);
                mismatch_count++;
            end else begin
                want = expected_status_q.pop_front();
                check_field("accepted", want.accepted, got.accepted);
                check_field("slot0_target", want.slot0_target, got.slot0_target);
                check_field("slot1_target", want.slot1_target, got.slot1_target);
                check_field("slot2_target", want.slot2_target, got.slot2_target);
                check_field("slot3_target", want.slot3_target, got.slot3_target);
                check_field("own_unit", want.own_unit, got.own_unit);
                check_field("current_unit", want.current_unit, got.current_unit);
                check_field("save_pending", want.save_pending, got.save_pending);
                check_field("delay_pending", want.delay_pending, got.delay_pending);
                check_field("auto_ready", want.auto_ready, got.auto_ready);
                check_field("long_pull", want.long_pull, got.long_pull);
                check_field("pull_check_flag", want.pull_check_flag, got.pull_check_flag);
            end
        end
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("filament_slot_command_decoder verification failed");
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/fscd_pkg.sv
sv/fscd_front.sv
sv/fscd_queue.sv
sv/fscd_back.sv
sv/filament_slot_command_decoder.sv
tb/filament_slot_command_decoder_test.sv
